// ===== hdl/priority_ready_queue_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_assert
// Assertion macros for the ready-queue scheduler.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define PRQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== hdl/prqs_pkg.sv =====
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and constants of the ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

    localparam int TASK_COUNT      = 64;
    localparam int PRIORITY_LEVELS = 32;
    localparam int TW = $clog2(TASK_COUNT);
    localparam int PW = $clog2(PRIORITY_LEVELS);
    localparam int LW = TW + 1;
    localparam logic [LW-1:0] NULL_ID = LW'(TASK_COUNT);

    localparam logic [1:0] OP_READY    = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_SCHEDULE = 2'd3;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic       load;   // capture request, read task tables
        logic       exec;   // perform the operation with read data
        logic       fin;    // find highest level, build result
    } prqs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       done;
    } prqs_sts_t;

endpackage

// ===== hdl/prqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// prqs_ctrl
// Sequencer: load, execute, finish, then hold the result until taken.
// ----------------------------------------------------------------------------
module prqs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_fire,
    input  prqs_pkg::prqs_sts_t sts,
    output prqs_pkg::prqs_cmd_t cmd,
    output logic                in_ready,
    output logic                out_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_EXEC;
            S_EXEC: state_next = S_FIN;
            S_FIN:  if (sts.done) state_next = S_OUT;
            S_OUT:  if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign cmd.load  = in_fire;
    assign cmd.exec  = (state_reg == S_EXEC);
    assign cmd.fin   = (state_reg == S_FIN);

endmodule

// ===== hdl/prqs_datapath.sv =====
// ----------------------------------------------------------------------------
// prqs_datapath
// Link memories, level tables, ready bitmap and the result register.
// ----------------------------------------------------------------------------
module prqs_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  prqs_pkg::prqs_cmd_t                 cmd,
    output prqs_pkg::prqs_sts_t                 sts,
    input  logic [1:0]                          operation,
    input  logic [prqs_pkg::TW-1:0]             task_id,
    input  logic [prqs_pkg::PW-1:0]             priority_req,
    input  logic [15:0]                         time_quanta,
    input  logic [5:0]                          idle_task,
    input  logic                                slicing_enable,
    output logic [prqs_pkg::TW-1:0]             next_task,
    output logic [prqs_pkg::PW-1:0]             next_priority,
    output logic                                any_ready,
    output logic                                switch_needed,
    output logic [6:0]                          level_count,
    output logic                                ignored
);

    localparam int TC = prqs_pkg::TASK_COUNT;
    localparam int PL = prqs_pkg::PRIORITY_LEVELS;
    localparam int TW = prqs_pkg::TW;
    localparam int PW = prqs_pkg::PW;
    localparam int LW = prqs_pkg::LW;
    localparam logic [LW-1:0] NID = prqs_pkg::NULL_ID;

    // Per-task stores without reset.
    logic [LW-1:0] next_mem [TC];
    logic [LW-1:0] prev_mem [TC];
    logic [PW-1:0] lvl_mem  [TC];
    logic [15:0]   cnt_mem  [TC];
    logic [15:0]   rld_mem  [TC];

    // Per-level tables and flags with reset.
    logic [LW-1:0] head_reg  [PL];
    logic [LW-1:0] tail_reg  [PL];
    logic [6:0]    ent_reg   [PL];
    logic [PL-1:0] ready_reg;
    logic [TC-1:0] inlist_reg;
    logic [LW-1:0] cur_task_reg;
    logic [PW-1:0] cur_prio_reg;

    // Captured request.
    logic [1:0]    op_reg;
    logic [TW-1:0] t_reg;
    logic [PW-1:0] p_reg;
    logic [15:0]   q_reg;

    // Reads registered in the load cycle.
    logic [LW-1:0] t_next_reg, t_prev_reg;
    logic [PW-1:0] t_lvl_reg;
    logic [LW-1:0] h_reg;
    logic [LW-1:0] h_next_reg;
    logic [15:0]   h_cnt_reg;

    // Result registers.
    logic [6:0] cnt_reg;
    logic       ign_reg, sw_reg;
    logic [TW-1:0] nt_reg;
    logic [PW-1:0] np_reg;
    logic          any_reg;

    logic [LW-1:0] hd_p;
    logic [LW-1:0] hd_n;
    logic [TW-1:0] h_idx;

    assign hd_p  = head_reg[priority_req];
    assign h_idx = hd_p[TW-1:0];

    // Load: capture fields, read the task and head link entries.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            t_reg      <= task_id;
            p_reg      <= priority_req;
            q_reg      <= time_quanta;
            t_next_reg <= next_mem[task_id];
            t_prev_reg <= prev_mem[task_id];
            t_lvl_reg  <= lvl_mem[task_id];
            h_reg      <= hd_p;
            h_next_reg <= next_mem[h_idx];
            h_cnt_reg  <= cnt_mem[h_idx];
        end
    end

    // Execute decisions.
    logic [PW-1:0] ul_p;
    logic          do_ins, do_rem, do_tick, do_rot, tick_act;
    logic [15:0]   dec_cnt;
    logic [LW-1:0] ins_old;
    logic          ins_tail;
    logic [LW-1:0] new_head;

    // Rotation bookkeeping carried from execute into finish.
    logic          rot_reg;
    logic [LW-1:0] rot_tail_reg;
    logic [15:0]   rld_new_reg;

    assign ul_p     = t_lvl_reg;
    assign do_ins   = (op_reg == prqs_pkg::OP_READY) && !inlist_reg[t_reg];
    assign do_rem   = (op_reg == prqs_pkg::OP_REMOVE) && inlist_reg[t_reg];
    assign tick_act = slicing_enable && (h_reg != NID) &&
                      (h_reg != LW'(idle_task));
    assign do_tick  = (op_reg == prqs_pkg::OP_TICK) && tick_act;
    assign dec_cnt  = (h_cnt_reg != 16'd0) ? h_cnt_reg - 16'd1 : 16'd0;
    assign do_rot   = do_tick && (dec_cnt == 16'd0) && (ent_reg[p_reg] >= 7'd2);
    assign ins_tail = (p_reg == cur_prio_reg);
    assign ins_old  = ins_tail ? tail_reg[p_reg] : head_reg[p_reg];
    assign new_head = h_next_reg;
    assign hd_n     = NID;

    // Execute and finish: link memory writes (at most one extra entry per memory).
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (do_ins)
            begin
                lvl_mem[t_reg] <= p_reg;
                rld_mem[t_reg] <= q_reg;
                cnt_mem[t_reg] <= q_reg;
                if (ent_reg[p_reg] == 7'd0)
                begin
                    next_mem[t_reg] <= NID;
                    prev_mem[t_reg] <= NID;
                end
                else if (ins_tail)
                begin
                    next_mem[t_reg] <= NID;
                    prev_mem[t_reg] <= ins_old;
                    next_mem[ins_old[TW-1:0]] <= LW'(t_reg);
                end
                else
                begin
                    next_mem[t_reg] <= ins_old;
                    prev_mem[t_reg] <= NID;
                    prev_mem[ins_old[TW-1:0]] <= LW'(t_reg);
                end
            end
            else if (do_rem)
            begin
                if (t_prev_reg != NID)
                    next_mem[t_prev_reg[TW-1:0]] <= t_next_reg;
                if (t_next_reg != NID)
                    prev_mem[t_next_reg[TW-1:0]] <= t_prev_reg;
            end
            else if (do_rot)
            begin
                // Old head moves to tail; second becomes head.
                prev_mem[new_head[TW-1:0]] <= NID;
                next_mem[h_reg[TW-1:0]]    <= NID;
                prev_mem[h_reg[TW-1:0]]    <= tail_reg[p_reg];
                cnt_mem[h_reg[TW-1:0]]     <= dec_cnt;
            end
            else if (do_tick)
                cnt_mem[h_reg[TW-1:0]] <= dec_cnt;
        end
        else if (cmd.fin && (op_reg == prqs_pkg::OP_TICK) && rot_reg)
        begin
            // Finish rotation: old tail links to old head, reload new head.
            next_mem[rot_tail_reg[TW-1:0]] <= h_reg;
            cnt_mem[new_head[TW-1:0]]      <= rld_new_reg;
        end
    end

    // Execute: keep the old tail and read the new head's reload value.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rot_tail_reg <= tail_reg[p_reg];
            rld_new_reg  <= rld_mem[new_head[TW-1:0]];
        end
    end

    // Highest ready level: lowest set bit of the bitmap.
    logic [PW-1:0] hi_p;
    always_comb
    begin
        hi_p = '0;
        for (int i = PL - 1; i >= 0; i--)
            if (ready_reg[i])
                hi_p = PW'(i);
    end

    // Execute: level tables, flags and current task.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PL; i++)
            begin
                head_reg[i] <= NID;
                tail_reg[i] <= NID;
                ent_reg[i]  <= '0;
            end
            ready_reg    <= '0;
            inlist_reg   <= '0;
            cur_task_reg <= NID;
            cur_prio_reg <= '0;
            rot_reg      <= 1'b0;
            sw_reg       <= 1'b0;
            ign_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (cmd.exec)
        begin
            rot_reg <= do_rot;
            sw_reg  <= 1'b0;
            ign_reg <= 1'b0;
            cnt_reg <= '0;
            unique case (op_reg)
                prqs_pkg::OP_READY:
                begin
                    if (!do_ins)
                    begin
                        ign_reg <= 1'b1;
                        cnt_reg <= ent_reg[t_lvl_reg];
                    end
                    else
                    begin
                        if (ent_reg[p_reg] == 7'd0)
                        begin
                            head_reg[p_reg] <= LW'(t_reg);
                            tail_reg[p_reg] <= LW'(t_reg);
                        end
                        else if (ins_tail)
                            tail_reg[p_reg] <= LW'(t_reg);
                        else
                            head_reg[p_reg] <= LW'(t_reg);
                        ent_reg[p_reg]    <= ent_reg[p_reg] + 7'd1;
                        cnt_reg           <= ent_reg[p_reg] + 7'd1;
                        ready_reg[p_reg]  <= 1'b1;
                        inlist_reg[t_reg] <= 1'b1;
                    end
                end
                prqs_pkg::OP_REMOVE:
                begin
                    if (!do_rem)
                        ign_reg <= 1'b1;
                    else
                    begin
                        inlist_reg[t_reg] <= 1'b0;
                        if (ent_reg[ul_p] <= 7'd1)
                        begin
                            ent_reg[ul_p]   <= '0;
                            head_reg[ul_p]  <= NID;
                            tail_reg[ul_p]  <= NID;
                            ready_reg[ul_p] <= 1'b0;
                            cnt_reg         <= '0;
                        end
                        else
                        begin
                            ent_reg[ul_p] <= ent_reg[ul_p] - 7'd1;
                            cnt_reg       <= ent_reg[ul_p] - 7'd1;
                            if (t_prev_reg == NID)
                                head_reg[ul_p] <= t_next_reg;
                            if (t_next_reg == NID)
                                tail_reg[ul_p] <= t_prev_reg;
                        end
                    end
                end
                prqs_pkg::OP_TICK:
                begin
                    cnt_reg <= ent_reg[p_reg];
                    if (do_rot)
                    begin
                        head_reg[p_reg] <= new_head;
                        tail_reg[p_reg] <= h_reg;
                    end
                end
                prqs_pkg::OP_SCHEDULE:
                begin
                    if (ready_reg != '0)
                    begin
                        sw_reg       <= (head_reg[hi_p] != cur_task_reg);
                        cur_task_reg <= head_reg[hi_p];
                        cur_prio_reg <= hi_p;
                        cnt_reg      <= ent_reg[hi_p];
                    end
                end
                default: ;
            endcase
        end
    end

    // Finish: register the highest ready head.
    logic [LW-1:0] hi_head;
    assign hi_head = head_reg[hi_p];

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            any_reg <= (ready_reg != '0);
            nt_reg  <= (ready_reg != '0) ? hi_head[TW-1:0] : '0;
            np_reg  <= (ready_reg != '0) ? hi_p : '0;
        end
    end

    assign sts.done      = cmd.fin && (hd_n == NID);
    assign next_task     = nt_reg;
    assign next_priority = np_reg;
    assign any_ready     = any_reg;
    assign switch_needed = sw_reg;
    assign level_count   = cnt_reg;
    assign ignored       = ign_reg;

endmodule

// ===== hdl/priority_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Ready-queue scheduler with per-priority linked task lists.
//
//  Channel  Direction  Content
//  s_axis   in         tdata: operation, task_id, priority_req, time_quanta
//  m_axis   out        tdata: next_task, next_priority, any_ready,
//                             switch_needed, level_count, ignored
//  cfg      in         0 idle_task, 1 slicing_enable
//
// A request reads its tables when it is accepted, updates them in the execute
// state and builds its result in the finish state; the result is valid from then.
// A result is held in its register until taken; no new request meanwhile.
// Reset is asynchronous and empties every level; no clearing pass.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_scheduler_assert.svh"

module priority_ready_queue_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] operation, [7:2] task_id, [12:8] priority_req,
    // [28:13] time_quanta, [31:29] zero
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] next_task, [10:6] next_priority, [11] any_ready,
    // [12] switch_needed, [19:13] level_count, [20] ignored, [23:21] zero
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam logic [0:0] REG_IDLE  = 1'd0;
    localparam logic [0:0] REG_SLICE = 1'd1;

    prqs_pkg::prqs_cmd_t cmd;
    prqs_pkg::prqs_sts_t sts;
    logic in_fire, out_fire;
    logic [5:0] idle_reg;
    logic       slice_reg;

    logic [5:0] nt;
    logic [4:0] np;
    logic       any, sw, ign;
    logic [6:0] cnt;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= 6'd63;
            slice_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IDLE:  idle_reg  <= cfg_data;
                REG_SLICE: slice_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    prqs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    prqs_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (s_axis_tdata[1:0]),
        .task_id        (s_axis_tdata[7:2]),
        .priority_req   (s_axis_tdata[12:8]),
        .time_quanta    (s_axis_tdata[28:13]),
        .idle_task      (idle_reg),
        .slicing_enable (slice_reg),
        .next_task      (nt),
        .next_priority  (np),
        .any_ready      (any),
        .switch_needed  (sw),
        .level_count    (cnt),
        .ignored        (ign)
    );

    assign m_axis_tdata = {3'b000, ign, cnt, sw, any, np, nt};

    `PRQ_ASSERT_IMP(a_no_accept_busy, m_axis_tvalid, !s_axis_tready)
    `PRQ_ASSERT_NEXT(a_accept_starts, in_fire, !m_axis_tvalid && !s_axis_tready)
    `PRQ_ASSERT_IMP(a_idle_result, m_axis_tvalid && !m_axis_tdata[11],
                    m_axis_tdata[10:0] == 11'd0)

endmodule

// ===== tb/tb_priority_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler
// Self-checking bench for the ready-queue scheduler. A queue-based driver
// sends make-ready, remove, tick and schedule requests with random gaps, and
// a monitor with random back-pressure checks every result against a
// behavioral copy of the per-level task lists kept in this bench.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler;

    localparam int CYCLE_LIMIT = 400000;

    localparam int TASK_COUNT      = prqs_pkg::TASK_COUNT;
    localparam int PRIORITY_LEVELS = prqs_pkg::PRIORITY_LEVELS;
    localparam int TW              = prqs_pkg::TW;
    localparam int LW              = prqs_pkg::LW;
    localparam logic [LW-1:0] NULL_ID = prqs_pkg::NULL_ID;

    typedef struct packed {
        logic [15:0] quanta;
        logic [4:0]  prio;
        logic [5:0]  task_id;
        logic [1:0]  op;
    } request_t;

    typedef struct packed {
        logic       ignored;
        logic [6:0] count;
        logic       switch_needed;
        logic       any_ready;
        logic [4:0] prio;
        logic [5:0] task_id;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [5:0]  cfg_data;

    localparam logic [0:0] REG_IDLE_TASK = 1'b0;
    localparam logic [0:0] REG_SLICING   = 1'b1;

    // Shadow scheduler state.
    logic [LW-1:0] nxt     [TASK_COUNT];
    logic [LW-1:0] prv     [TASK_COUNT];
    logic [LW-1:0] head    [PRIORITY_LEVELS];
    logic [LW-1:0] tail    [PRIORITY_LEVELS];
    logic [6:0]    entries [PRIORITY_LEVELS];
    logic [4:0]    lvl     [TASK_COUNT];
    logic          linked  [TASK_COUNT];
    logic [15:0]   slice   [TASK_COUNT];
    logic [15:0]   reload  [TASK_COUNT];
    logic [LW-1:0] cur_task;
    logic [4:0]    cur_prio;
    logic [5:0]    idle_id;
    logic          slicing_on;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       errors;
    int       cycles;
    int       send_wait;
    int       take_wait;

    priority_ready_queue_scheduler u_top (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int top_level();
        for (int p = 0; p < PRIORITY_LEVELS; p++)
        begin
            if (entries[p] != 0)
                return p;
        end
        return -1;
    endfunction

    // Apply one request to the shadow lists and return the result it gives.
    function automatic result_t schedule_step(request_t rq);
        result_t  r;
        int       hp;
        logic [LW-1:0] h, t2, a, b, sec;
        logic [4:0] p;
        r = '0;
        p = rq.prio;
        case (rq.op)
            prqs_pkg::OP_READY:
            begin
                if (linked[rq.task_id])
                begin
                    r.ignored = 1'b1;
                    r.count = entries[lvl[rq.task_id]];
                end
                else
                begin
                    lvl[rq.task_id] = p;
                    reload[rq.task_id] = rq.quanta;
                    slice[rq.task_id] = rq.quanta;
                    if (entries[p] == 0)
                    begin
                        nxt[rq.task_id] = NULL_ID;
                        prv[rq.task_id] = NULL_ID;
                        head[p] = LW'(rq.task_id);
                        tail[p] = LW'(rq.task_id);
                    end
                    else if (p == cur_prio)
                    begin
                        t2 = tail[p];
                        nxt[rq.task_id] = NULL_ID;
                        prv[rq.task_id] = t2;
                        nxt[t2[TW-1:0]] = LW'(rq.task_id);
                        tail[p] = LW'(rq.task_id);
                    end
                    else
                    begin
                        h = head[p];
                        nxt[rq.task_id] = h;
                        prv[rq.task_id] = NULL_ID;
                        prv[h[TW-1:0]] = LW'(rq.task_id);
                        head[p] = LW'(rq.task_id);
                    end
                    entries[p]++;
                    linked[rq.task_id] = 1'b1;
                    r.count = entries[p];
                end
            end
            prqs_pkg::OP_REMOVE:
            begin
                if (!linked[rq.task_id])
                    r.ignored = 1'b1;
                else
                begin
                    p = lvl[rq.task_id];
                    b = prv[rq.task_id];
                    a = nxt[rq.task_id];
                    if (b == NULL_ID) head[p] = a;
                    else nxt[b[TW-1:0]] = a;
                    if (a == NULL_ID) tail[p] = b;
                    else prv[a[TW-1:0]] = b;
                    if (entries[p] > 0) entries[p]--;
                    if (entries[p] == 0)
                    begin
                        head[p] = NULL_ID;
                        tail[p] = NULL_ID;
                    end
                    nxt[rq.task_id] = NULL_ID;
                    prv[rq.task_id] = NULL_ID;
                    linked[rq.task_id] = 1'b0;
                    r.count = entries[p];
                end
            end
            prqs_pkg::OP_TICK:
            begin
                h = head[p];
                if (slicing_on && h != NULL_ID && h[TW-1:0] != idle_id)
                begin
                    if (slice[h[TW-1:0]] > 0) slice[h[TW-1:0]]--;
                    if (slice[h[TW-1:0]] == 0 && entries[p] >= 2)
                    begin
                        t2 = tail[p];
                        sec = nxt[h[TW-1:0]];
                        prv[sec[TW-1:0]] = NULL_ID;
                        nxt[h[TW-1:0]] = NULL_ID;
                        prv[h[TW-1:0]] = t2;
                        nxt[t2[TW-1:0]] = h;
                        head[p] = sec;
                        tail[p] = h;
                        slice[sec[TW-1:0]] = reload[sec[TW-1:0]];
                    end
                end
                r.count = entries[p];
            end
            default:
            begin
                hp = top_level();
                if (hp >= 0)
                begin
                    r.switch_needed = (head[hp] != cur_task);
                    cur_task = head[hp];
                    cur_prio = hp[4:0];
                    r.count = entries[hp];
                end
            end
        endcase
        hp = top_level();
        if (hp >= 0)
        begin
            h = head[hp];
            r.task_id = h[TW-1:0];
            r.prio = hp[4:0];
            r.any_ready = 1'b1;
        end
        return r;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [5:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IDLE_TASK) idle_id = value;
        else slicing_on = value[0];
    endtask

    task automatic push_request(logic [1:0] op, int tid, int prio, int quanta);
        request_t rq;
        rq.op = op;
        rq.task_id = tid[5:0];
        rq.prio = prio[4:0];
        rq.quanta = quanta[15:0];
        pending_requests.push_back(rq);
    endtask

    // Wait for the block to drain before touching the registers.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Random phase: make-ready requests on levels 0 to level_span, mostly with short
    // slices, ticks on the same levels, removes and schedules.
    task automatic random_phase(int n, int level_span);
        int sel, t;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            t = $urandom_range(0, TASK_COUNT - 1);
            if (sel < 35)
                push_request(prqs_pkg::OP_READY, t, $urandom_range(0, level_span),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 3));
            else if (sel < 55)
                push_request(prqs_pkg::OP_REMOVE, t, $urandom_range(0, 31), $urandom);
            else if (sel < 85)
                push_request(prqs_pkg::OP_TICK, $urandom, $urandom_range(0, level_span),
                             $urandom);
            else
                push_request(prqs_pkg::OP_SCHEDULE, $urandom, $urandom, $urandom);
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_wait <= 0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
        begin
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            // Accepted; draw the gap before the next request.
            expected_results.push_back(schedule_step(pending_requests.pop_front()));
            gap = $urandom_range(0, 4);
            if (gap == 0 && pending_requests.size() != 0)
                s_axis_tdata <= {3'b000, pending_requests[0]};
            else
            begin
                s_axis_tvalid <= 1'b0;
                send_wait <= (gap == 0) ? 0 : gap - 1;
            end
        end
        else if (send_wait > 0)
            send_wait <= send_wait - 1;
        else if (pending_requests.size() != 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {3'b000, pending_requests[0]};
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            take_wait <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[20:0];
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: %h", got);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.task_id != want.task_id)
                    begin
                        $error("next_task exp %0d got %0d", want.task_id, got.task_id);
                        errors++;
                    end
                    if (got.prio != want.prio)
                    begin
                        $error("next_priority exp %0d got %0d", want.prio, got.prio);
                        errors++;
                    end
                    if (got.any_ready != want.any_ready)
                    begin
                        $error("any_ready exp %0d got %0d", want.any_ready, got.any_ready);
                        errors++;
                    end
                    if (got.switch_needed != want.switch_needed)
                    begin
                        $error("switch_needed exp %0d got %0d", want.switch_needed,
                               got.switch_needed);
                        errors++;
                    end
                    if (got.count != want.count)
                    begin
                        $error("level_count exp %0d got %0d", want.count, got.count);
                        errors++;
                    end
                    if (got.ignored != want.ignored)
                    begin
                        $error("ignored exp %0d got %0d", want.ignored, got.ignored);
                        errors++;
                    end
                end
                take_wait <= $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
            else if (take_wait > 0)
                take_wait <= take_wait - 1;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_priority_ready_queue_scheduler: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IDLE_TASK;
        cfg_data = '0;
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            nxt[i] = NULL_ID;
            prv[i] = NULL_ID;
            lvl[i] = '0;
            linked[i] = 1'b0;
            slice[i] = '0;
            reload[i] = '0;
        end
        for (int i = 0; i < PRIORITY_LEVELS; i++)
        begin
            head[i] = NULL_ID;
            tail[i] = NULL_ID;
            entries[i] = '0;
        end
        cur_task = NULL_ID;
        cur_prio = '0;
        idle_id = 6'd63;
        slicing_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty schedule, extremes, duplicates, unready removes.
        push_request(prqs_pkg::OP_SCHEDULE, 0, 0, 0);
        push_request(prqs_pkg::OP_TICK, 0, 31, 0);
        push_request(prqs_pkg::OP_REMOVE, 5, 0, 0);
        push_request(prqs_pkg::OP_READY, 0, 0, 0);
        push_request(prqs_pkg::OP_READY, 63, 31, 65535);
        push_request(prqs_pkg::OP_READY, 0, 3, 1);
        push_request(prqs_pkg::OP_READY, 1, 0, 2);
        push_request(prqs_pkg::OP_READY, 2, 0, 0);
        push_request(prqs_pkg::OP_SCHEDULE, 0, 0, 0);
        push_request(prqs_pkg::OP_READY, 3, 0, 1);
        push_request(prqs_pkg::OP_TICK, 0, 0, 0);
        push_request(prqs_pkg::OP_TICK, 0, 0, 0);
        push_request(prqs_pkg::OP_TICK, 0, 0, 0);
        push_request(prqs_pkg::OP_TICK, 0, 31, 0);
        push_request(prqs_pkg::OP_SCHEDULE, 0, 0, 0);
        push_request(prqs_pkg::OP_REMOVE, 1, 0, 0);
        push_request(prqs_pkg::OP_REMOVE, 63, 0, 0);
        push_request(prqs_pkg::OP_REMOVE, 63, 0, 0);
        push_request(prqs_pkg::OP_READY, 42, 21, 43690);
        push_request(prqs_pkg::OP_READY, 21, 10, 21845);
        push_request(prqs_pkg::OP_SCHEDULE, 0, 0, 0);
        wait_idle();

        // Random phases under several register settings.
        random_phase(450, 3);
        wait_idle();
        write_reg(REG_IDLE_TASK, 6'd0);
        write_reg(REG_SLICING, 6'd0);
        random_phase(200, 31);
        wait_idle();
        write_reg(REG_SLICING, 6'd1);
        write_reg(REG_IDLE_TASK, 6'($urandom_range(0, 63)));
        random_phase(350, 1);
        wait_idle();
        write_reg(REG_IDLE_TASK, 6'd63);
        random_phase(250, 7);
        wait_idle();

        if (errors == 0)
            $display("tb_priority_ready_queue_scheduler: done, clean");
        else
            $display("tb_priority_ready_queue_scheduler: done, errors");
        $finish;
    end
endmodule
